/* sv/lru_pkg.sv */
// Package with the shared types and constants of the LRU cache hit/miss model.
package lru_pkg;

  localparam int LINES        = 1024;
  localparam int LINE_BITS    = 10;
  localparam int WAY_CNT_BITS = LINE_BITS + 1;
  localparam int ADDR_BITS    = 32;
  localparam int TAG_BITS     = 30;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LOG2 = 2'd2;

  localparam logic [2:0] MODE_DIRECT = 3'd1;
  localparam logic [2:0] MODE_TWO    = 3'd3;
  localparam logic [2:0] MODE_FOUR   = 3'd4;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_GEO,
    ST_SCAN,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [31:0] address;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic        writeback;
    logic [31:0] total_accesses;
    logic [31:0] total_hits;
    logic [31:0] total_misses;
    logic [31:0] read_count;
    logic [31:0] read_hit_count;
    logic [31:0] write_count;
    logic [31:0] write_hit_count;
  } out_t;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [TAG_BITS-1:0] tag;
    logic [31:0]         stamp;
  } line_t;

endpackage

/* sv/lru_cache_hit_miss_model.sv */
// Top level of the tag-only set-associative LRU cache hit/miss model.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   in      | in_valid, in_ready, in_data    | transaction in
//   out     | out_valid, out_ready, out_data | transaction out
//   cfg     | cfg_we, cfg_index, cfg_wdata   | register write
//
// A transaction passes through accept, geometry, one registered line read per way of the set
// (W ways, 1 to 1024; a hit ends the scan at its way) through the single read port of the line
// memory, and one update step that writes the line back. After reset a clearing pass writes
// all 1024 lines with in_ready low.
// A result waits in the output register; the next transaction may be accepted meanwhile,
// and its update cycle stalls until the output register is free.
module lru_cache_hit_miss_model
  import lru_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  line_t line_mem [LINES];

  state_t                  state_r, state_nxt;
  logic [2:0]              mode_r;
  logic [3:0]              bsl_r;
  logic [4:0]              csl_r;
  logic [LINE_BITS-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                    op_r, op_nxt;
  logic [31:0]             addr_r, addr_nxt;
  logic [TAG_BITS-1:0]     tag_r, tag_nxt;
  logic [LINE_BITS-1:0]    base_r, base_nxt;
  logic [WAY_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [LINE_BITS-1:0]    chk_way_r, chk_way_nxt;
  line_t                   rd_data_r;
  logic                    hit_r, hit_nxt;
  logic                    hit_dirty_r, hit_dirty_nxt;
  logic [LINE_BITS-1:0]    hit_way_r, hit_way_nxt;
  logic                    inv_r, inv_nxt;
  logic [LINE_BITS-1:0]    inv_way_r, inv_way_nxt;
  logic [LINE_BITS-1:0]    min_way_r, min_way_nxt;
  logic [31:0]             min_stamp_r, min_stamp_nxt;
  logic                    min_dirty_r, min_dirty_nxt;
  logic [31:0]             clock_r, clock_nxt;
  out_t                    out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [3:0]              off;
  logic [4:0]              nblk;
  logic [3:0]              wsel;
  logic [3:0]              w;
  logic [3:0]              idx_bits;
  logic [WAY_CNT_BITS-1:0] ways;
  logic [31:0]             shifted;
  logic [LINE_BITS-1:0]    set_idx;
  logic                    rd_en;
  logic [LINE_BITS-1:0]    rd_addr;
  logic                    wr_en;
  logic [LINE_BITS-1:0]    wr_addr;
  line_t                   wr_data;
  logic                    issue;
  logic                    match;
  logic                    last_way;
  logic                    upd_go;
  logic [LINE_BITS-1:0]    vic_way;

  always_comb begin
    off = (bsl_r < 4'd2) ? 4'd2 : bsl_r;
    nblk = (csl_r > {1'b0, off}) ? csl_r - {1'b0, off} : 5'd0;
    if (nblk > 5'(LINE_BITS)) begin
      nblk = 5'(LINE_BITS);
    end
    case (mode_r)
      MODE_DIRECT: wsel = 4'd0;
      MODE_TWO:    wsel = 4'd1;
      MODE_FOUR:   wsel = 4'd2;
      default:     wsel = nblk[3:0];
    endcase
    w = ({1'b0, wsel} > nblk) ? nblk[3:0] : wsel;
    idx_bits = nblk[3:0] - w;
    ways = WAY_CNT_BITS'(1) << w;
    shifted = addr_r >> off;
    set_idx = shifted[LINE_BITS-1:0] & LINE_BITS'((LINE_BITS'(1) << idx_bits) - 1'b1);
  end

  assign issue    = (state_r == ST_SCAN) && (cnt_r < ways);
  assign match    = chk_vld_r && rd_data_r.valid && (rd_data_r.tag == tag_r);
  assign last_way = chk_vld_r && ({1'b0, chk_way_r} == ways - 1'b1);
  assign upd_go   = !out_valid_r || out_ready;
  assign vic_way  = inv_r ? inv_way_r : min_way_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LINE_BITS'(LINES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_GEO;
        end
      end
      ST_GEO: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (match || last_way) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    clr_cnt_nxt   = clr_cnt_r + 1'b1;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    tag_nxt       = tag_r;
    base_nxt      = base_r;
    cnt_nxt       = cnt_r;
    chk_vld_nxt   = issue;
    chk_way_nxt   = cnt_r[LINE_BITS-1:0];
    hit_nxt       = hit_r;
    hit_dirty_nxt = hit_dirty_r;
    hit_way_nxt   = hit_way_r;
    inv_nxt       = inv_r;
    inv_way_nxt   = inv_way_r;
    min_way_nxt   = min_way_r;
    min_stamp_nxt = min_stamp_r;
    min_dirty_nxt = min_dirty_r;
    clock_nxt     = clock_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = issue;
    rd_addr       = base_r + cnt_r[LINE_BITS-1:0];
    wr_en         = 1'b0;
    wr_addr       = clr_cnt_r;
    wr_data       = '0;
    case (state_r)
      ST_CLEAR: wr_en = 1'b1;
      ST_IDLE: begin
        op_nxt   = in_data.operation;
        addr_nxt = in_data.address;
      end
      ST_GEO: begin
        tag_nxt  = TAG_BITS'(addr_r >> ({1'b0, off} + {1'b0, idx_bits}));
        base_nxt = set_idx << w;
        cnt_nxt  = '0;
        hit_nxt  = 1'b0;
        inv_nxt  = 1'b0;
      end
      ST_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (match) begin
          hit_nxt       = 1'b1;
          hit_dirty_nxt = rd_data_r.dirty;
          hit_way_nxt   = chk_way_r;
          chk_vld_nxt   = 1'b0;
        end else if (chk_vld_r) begin
          if (!rd_data_r.valid && !inv_r) begin
            inv_nxt     = 1'b1;
            inv_way_nxt = chk_way_r;
          end
          if ((chk_way_r == '0) || (rd_data_r.stamp < min_stamp_r)) begin
            min_way_nxt   = chk_way_r;
            min_stamp_nxt = rd_data_r.stamp;
            min_dirty_nxt = rd_data_r.dirty;
          end
          if (last_way) begin
            chk_vld_nxt = 1'b0;
          end
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          clock_nxt     = clock_r + 1'b1;
          wr_en         = 1'b1;
          wr_addr       = base_r + (hit_r ? hit_way_r : vic_way);
          wr_data.valid = 1'b1;
          wr_data.dirty = hit_r && (hit_dirty_r || op_r);
          wr_data.tag   = tag_r;
          wr_data.stamp = clock_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt.hit            = hit_r;
          out_nxt.writeback      = !hit_r && !inv_r && min_dirty_r;
          out_nxt.total_accesses = out_r.total_accesses + 1'b1;
          out_nxt.total_hits     = out_r.total_hits + 32'(hit_r);
          out_nxt.total_misses   = out_r.total_misses + 32'(!hit_r);
          out_nxt.read_count     = out_r.read_count + 32'(!op_r);
          out_nxt.read_hit_count = out_r.read_hit_count + 32'(!op_r && hit_r);
          out_nxt.write_count    = out_r.write_count + 32'(op_r);
          out_nxt.write_hit_count = out_r.write_hit_count + 32'(op_r && hit_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      mode_r      <= MODE_DIRECT;
      bsl_r       <= 4'd4;
      csl_r       <= 5'd10;
      clock_r     <= '0;
      out_r       <= '0;
      out_valid_r <= 1'b0;
      chk_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clock_r     <= clock_nxt;
      out_r       <= out_nxt;
      out_valid_r <= out_valid_nxt;
      chk_vld_r   <= chk_vld_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_ASSOC_MODE: mode_r <= cfg_wdata[2:0];
          CFG_BLOCK_LOG2: bsl_r  <= cfg_wdata[3:0];
          CFG_CACHE_LOG2: csl_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    addr_r      <= addr_nxt;
    tag_r       <= tag_nxt;
    base_r      <= base_nxt;
    cnt_r       <= cnt_nxt;
    chk_way_r   <= chk_way_nxt;
    hit_r       <= hit_nxt;
    hit_dirty_r <= hit_dirty_nxt;
    hit_way_r   <= hit_way_nxt;
    inv_r       <= inv_nxt;
    inv_way_r   <= inv_way_nxt;
    min_way_r   <= min_way_nxt;
    min_stamp_r <= min_stamp_nxt;
    min_dirty_r <= min_dirty_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_hits_misses: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.total_hits + out_r.total_misses == out_r.total_accesses))
    else $error("hit and miss counts do not add up to the access count");

  a_reads_writes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.read_count + out_r.write_count == out_r.total_accesses))
    else $error("read and write counts do not add up to the access count");

  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && upd_go) |=> (clock_r == $past(clock_r) + 32'd1))
    else $error("access clock did not advance on update");

  a_check_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && chk_vld_r) |-> ({1'b0, chk_way_r} < ways))
    else $error("way check beyond the ways of the set");

endmodule
